>>> rtl/pwe_pkg.sv
// shared types and constants for the pwm expander write sequencer
package pwe_pkg;

  localparam int OSC_W   = 26;
  localparam int FREQ_W  = 11;
  localparam int PWM_W   = 13;
  localparam int QUOT_W  = 16;
  localparam int REM_W   = 11;
  localparam int QUEUE_DEPTH = 2;
  localparam int DIV_STEPS   = 8;

  localparam logic [OSC_W-1:0]  OSC_RESET = 26'd25000000;

  localparam logic [FREQ_W-1:0] FREQ_MIN  = 11'd24;
  localparam logic [FREQ_W-1:0] FREQ_MAX  = 11'd1526;
  localparam logic [FREQ_W-1:0] FREQ_INIT = 11'd200;

  localparam logic [QUOT_W-1:0] PRE_MIN = 16'd3;
  localparam logic [QUOT_W-1:0] PRE_MAX = 16'd255;

  localparam logic [6:0] DUTY_MAX = 7'd100;
  localparam logic [PWM_W-1:0] PWM_FULL = 13'h1000;

  localparam logic [7:0] ADDR_MODE1    = 8'h00;
  localparam logic [7:0] ADDR_MODE2    = 8'h01;
  localparam logic [7:0] ADDR_PRESCALE = 8'hFE;
  localparam logic [7:0] REG_LED_BASE  = 8'h06;

  localparam logic [7:0] MODE1_SLEEP_AI   = 8'h30;
  localparam logic [7:0] MODE1_AUTO_INC   = 8'h20;
  localparam logic [7:0] MODE1_RESTART_AI = 8'hA0;
  localparam logic [7:0] MODE2_INIT       = 8'h04;

  // last step index of each command kind
  localparam logic [2:0] INIT_LAST_STEP = 3'd4;
  localparam logic [2:0] SET_LAST_STEP  = 3'd7;

  typedef struct packed {
    logic             err;
    logic             init;
    logic [7:0]       base;
    logic [PWM_W-1:0] on_cnt;
    logic [PWM_W-1:0] off_cnt;
    logic [7:0]       pre;
  } desc_t;

  typedef struct packed {
    logic [7:0] reg_addr;
    logic [7:0] reg_value;
    logic       burst_continue;
    logic       wait_first;
    logic       error;
    logic       last;
  } result_t;

endpackage

>>> rtl/pwe_front.sv
// front end: accepts commands, classifies them and computes the prescale
module pwe_front #(
  parameter int NUM_CHANNELS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [pwe_pkg::OSC_W-1:0]   osc_i,
  input  logic                        in_push,
  output logic                        in_full,
  input  logic                        in_command,
  input  logic [7:0]                  in_channel,
  input  logic [15:0]                 in_frequency_hz,
  input  logic [7:0]                  in_duty_percent,
  output pwe_pkg::desc_t              desc_o,
  output logic                        q_push_o,
  input  logic                        q_full_i
);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_DIV  = 3'b010,
    F_DONE = 3'b100
  } fstate_t;

  localparam int CNT_W = $clog2(pwe_pkg::DIV_STEPS);

  fstate_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  pwe_pkg::desc_t desc_r, desc_nxt;
  logic [pwe_pkg::REM_W-1:0]  rem_r, rem_nxt;
  logic [pwe_pkg::QUOT_W-1:0] dvd_r, dvd_nxt;
  logic [pwe_pkg::QUOT_W-1:0] quot_r, quot_nxt;
  logic [pwe_pkg::FREQ_W-1:0] div_r, div_nxt;

  logic accept;
  logic bad_cmd;
  logic [pwe_pkg::FREQ_W-1:0] freq_c;
  logic [pwe_pkg::OSC_W:0]    num;
  logic [6:0]                 duty_c;
  logic [pwe_pkg::PWM_W-1:0]  duty_w, mul41, ceil20;
  logic [pwe_pkg::PWM_W-1:0]  on_c, off_c;
  logic [pwe_pkg::REM_W:0]    sh0, sh1;
  logic [pwe_pkg::REM_W-1:0]  rem_a, rem_b;
  logic                       qb0, qb1;

  assign accept   = in_push && (state_r == F_IDLE);
  assign in_full  = (state_r != F_IDLE);
  assign q_push_o = (state_r == F_DONE) && !q_full_i;

  assign bad_cmd = in_command &&
                   (({1'b0, in_channel} >= 9'(NUM_CHANNELS)) || (in_frequency_hz == 16'd0));

  // frequency clamp, init runs at a fixed rate
  always_comb begin
    if (!in_command) begin
      freq_c = pwe_pkg::FREQ_INIT;
    end else if (in_frequency_hz < 16'(pwe_pkg::FREQ_MIN)) begin
      freq_c = pwe_pkg::FREQ_MIN;
    end else if (in_frequency_hz > 16'(pwe_pkg::FREQ_MAX)) begin
      freq_c = pwe_pkg::FREQ_MAX;
    end else begin
      freq_c = in_frequency_hz[pwe_pkg::FREQ_W-1:0];
    end
  end

  // (osc + 2048 f) / (4096 f) == ((osc + 2048 f) >> 12) / f
  assign num = {1'b0, osc_i} + {5'd0, freq_c, 11'd0};

  // off = floor(41 d - d / 20) = 41 d - ceil(d / 20)
  assign duty_c = (in_duty_percent > 8'(pwe_pkg::DUTY_MAX)) ? pwe_pkg::DUTY_MAX
                                                             : in_duty_percent[6:0];
  assign duty_w = pwe_pkg::PWM_W'(duty_c);
  assign mul41  = (duty_w << 5) + (duty_w << 3) + duty_w;
  assign ceil20 = pwe_pkg::PWM_W'(duty_c > 7'd0)  + pwe_pkg::PWM_W'(duty_c > 7'd20) +
                  pwe_pkg::PWM_W'(duty_c > 7'd40) + pwe_pkg::PWM_W'(duty_c > 7'd60) +
                  pwe_pkg::PWM_W'(duty_c > 7'd80);

  always_comb begin
    on_c  = '0;
    off_c = '0;
    if (duty_c == 7'd0) begin
      off_c = pwe_pkg::PWM_FULL;
    end else if (duty_c == pwe_pkg::DUTY_MAX) begin
      on_c = pwe_pkg::PWM_FULL;
    end else begin
      off_c = mul41 - ceil20;
    end
  end

  // two restoring division steps per cycle
  assign sh0   = {rem_r, dvd_r[pwe_pkg::QUOT_W-1]};
  assign qb0   = (sh0 >= {1'b0, div_r});
  assign rem_a = qb0 ? pwe_pkg::REM_W'(sh0 - {1'b0, div_r}) : sh0[pwe_pkg::REM_W-1:0];
  assign sh1   = {rem_a, dvd_r[pwe_pkg::QUOT_W-2]};
  assign qb1   = (sh1 >= {1'b0, div_r});
  assign rem_b = qb1 ? pwe_pkg::REM_W'(sh1 - {1'b0, div_r}) : sh1[pwe_pkg::REM_W-1:0];

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    desc_nxt  = desc_r;
    rem_nxt   = rem_r;
    dvd_nxt   = dvd_r;
    quot_nxt  = quot_r;
    div_nxt   = div_r;
    unique case (state_r)
      F_IDLE: begin
        if (accept) begin
          desc_nxt.err     = bad_cmd;
          desc_nxt.init    = !in_command;
          desc_nxt.base    = pwe_pkg::REG_LED_BASE + {in_channel[5:0], 2'b00};
          desc_nxt.on_cnt  = on_c;
          desc_nxt.off_cnt = off_c;
          desc_nxt.pre     = '0;
          rem_nxt  = '0;
          quot_nxt = '0;
          cnt_nxt  = '0;
          dvd_nxt  = {1'b0, num[pwe_pkg::OSC_W:12]};
          div_nxt  = freq_c;
          state_nxt = bad_cmd ? F_DONE : F_DIV;
        end
      end
      F_DIV: begin
        rem_nxt  = rem_b;
        dvd_nxt  = {dvd_r[pwe_pkg::QUOT_W-3:0], 2'b00};
        quot_nxt = {quot_r[pwe_pkg::QUOT_W-3:0], qb0, qb1};
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(pwe_pkg::DIV_STEPS - 1)) begin
          state_nxt = F_DONE;
        end
      end
      F_DONE: begin
        if (!q_full_i) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_comb begin
    desc_o = desc_r;
    if (quot_r > pwe_pkg::PRE_MAX) begin
      desc_o.pre = pwe_pkg::PRE_MAX[7:0];
    end else if (quot_r < pwe_pkg::PRE_MIN) begin
      desc_o.pre = pwe_pkg::PRE_MIN[7:0];
    end else begin
      desc_o.pre = quot_r[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    desc_r <= desc_nxt;
    rem_r  <= rem_nxt;
    dvd_r  <= dvd_nxt;
    quot_r <= quot_nxt;
    div_r  <= div_nxt;
  end

endmodule

>>> rtl/pwe_queue.sv
// short descriptor queue between the front and back ends
module pwe_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_i,
  input  pwe_pkg::desc_t wdata_i,
  output logic           full_o,
  input  logic           pop_i,
  output pwe_pkg::desc_t rdata_o,
  output logic           valid_o
);

  localparam int DEPTH = pwe_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  pwe_pkg::desc_t mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full_o  = (count_r == CNT_W'(DEPTH));
  assign valid_o = (count_r != '0);
  assign rdata_o = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_i) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_nxt = count_r + 1'b1;
    end else if (pop_i && !push_i) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      mem_r[wr_ptr_r] <= wdata_i;
    end
  end

`ifndef ASSERT_OFF
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push_i |-> !full_o)
    else $error("descriptor written into a full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop_i |-> valid_o)
    else $error("descriptor read from an empty queue");
`endif

endmodule

>>> rtl/pwe_back.sv
// back end: expands a descriptor into register writes, one per cycle unless an unpopped write holds the output
module pwe_back (
  input  logic           clk,
  input  logic           rst_n,
  input  pwe_pkg::desc_t desc_i,
  input  logic           q_valid_i,
  output logic           q_pop_o,
  output logic           out_empty,
  input  logic           out_pop,
  output logic [7:0]     out_reg_addr,
  output logic [7:0]     out_reg_value,
  output logic           out_burst_continue,
  output logic           out_wait_first,
  output logic           out_error,
  output logic           out_last
);

  logic active_r, active_nxt;
  pwe_pkg::desc_t desc_r, desc_nxt;
  logic [2:0] step_r, step_nxt;
  logic ov_r, ov_nxt;
  pwe_pkg::result_t res_r, res_nxt, res_c;

  logic adv, load;
  logic [1:0] fidx;
  logic       in_fprog;

  // which step of the frequency program this step is, if any
  always_comb begin
    if (desc_r.init) begin
      fidx     = 2'(step_r - 3'd1);
      in_fprog = (step_r != 3'd0);
    end else begin
      fidx     = step_r[1:0];
      in_fprog = !step_r[2];
    end
  end

  always_comb begin
    res_c = '0;
    if (desc_r.err) begin
      res_c.error = 1'b1;
      res_c.last  = 1'b1;
    end else if (in_fprog) begin
      case (fidx)
        2'd0: begin
          res_c.reg_addr  = pwe_pkg::ADDR_MODE1;
          res_c.reg_value = pwe_pkg::MODE1_SLEEP_AI;
        end
        2'd1: begin
          res_c.reg_addr  = pwe_pkg::ADDR_PRESCALE;
          res_c.reg_value = desc_r.pre;
        end
        2'd2: begin
          res_c.reg_addr  = pwe_pkg::ADDR_MODE1;
          res_c.reg_value = pwe_pkg::MODE1_AUTO_INC;
        end
        default: begin
          res_c.reg_addr   = pwe_pkg::ADDR_MODE1;
          res_c.reg_value  = pwe_pkg::MODE1_RESTART_AI;
          res_c.wait_first = 1'b1;
        end
      endcase
      res_c.last = desc_r.init && (step_r == pwe_pkg::INIT_LAST_STEP);
    end else if (desc_r.init) begin
      res_c.reg_addr  = pwe_pkg::ADDR_MODE2;
      res_c.reg_value = pwe_pkg::MODE2_INIT;
    end else begin
      // on/off burst at the channel's register block
      res_c.reg_addr       = desc_r.base + {6'd0, step_r[1:0]};
      res_c.burst_continue = (step_r[1:0] != 2'd0);
      case (step_r[1:0])
        2'd0:    res_c.reg_value = desc_r.on_cnt[7:0];
        2'd1:    res_c.reg_value = 8'(desc_r.on_cnt[pwe_pkg::PWM_W-1:8]);
        2'd2:    res_c.reg_value = desc_r.off_cnt[7:0];
        default: res_c.reg_value = 8'(desc_r.off_cnt[pwe_pkg::PWM_W-1:8]);
      endcase
      res_c.last = (step_r == pwe_pkg::SET_LAST_STEP);
    end
  end

  assign adv     = active_r && (!ov_r || out_pop);
  assign load    = q_valid_i && (!active_r || (adv && res_c.last));
  assign q_pop_o = load;

  always_comb begin
    active_nxt = active_r;
    desc_nxt   = desc_r;
    step_nxt   = step_r;
    ov_nxt     = ov_r;
    res_nxt    = res_r;
    if (load) begin
      active_nxt = 1'b1;
      desc_nxt   = desc_i;
      step_nxt   = '0;
    end else if (adv && res_c.last) begin
      active_nxt = 1'b0;
    end else if (adv) begin
      step_nxt = step_r + 1'b1;
    end
    if (adv) begin
      ov_nxt  = 1'b1;
      res_nxt = res_c;
    end else if (out_pop) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      active_r <= active_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    desc_r <= desc_nxt;
    step_r <= step_nxt;
    res_r  <= res_nxt;
  end

  assign out_empty          = !ov_r;
  assign out_reg_addr       = res_r.reg_addr;
  assign out_reg_value      = res_r.reg_value;
  assign out_burst_continue = res_r.burst_continue;
  assign out_wait_first     = res_r.wait_first;
  assign out_error          = res_r.error;
  assign out_last           = res_r.last;

`ifndef ASSERT_OFF
  a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
    (active_r && desc_r.err) |-> (step_r == 3'd0))
    else $error("rejected command ran past its single result");

  a_init_len: assert property (@(posedge clk) disable iff (!rst_n)
    (active_r && desc_r.init && !desc_r.err) |-> (step_r <= pwe_pkg::INIT_LAST_STEP))
    else $error("init sequence ran past its last write");

  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && res_c.last && !q_valid_i) |=> !active_r)
    else $error("sequencer stayed busy after the last write");
`endif

endmodule

>>> rtl/pwm_expander_write_sequencer_top.sv
// top level of the pwm expander write sequencer
// an accepted item runs through the front end's radix-4 prescale divider (a rejected
// item skips it), and its descriptor is then pushed into the back end's queue. the
// front takes no new item until the last one has been pushed; the back end emits
// one write per cycle unless an unpopped write holds its output, 8 per set-pwm item.
// synchronous active-low reset empties the queue and output and sets osc_hz to
// 25000000; no clearing pass
module pwm_expander_write_sequencer_top #(
  parameter int NUM_CHANNELS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [pwe_pkg::OSC_W-1:0] cfg_data,
  input  logic                      in_push,
  output logic                      in_full,
  input  logic                      in_command,
  input  logic [7:0]                in_channel,
  input  logic [15:0]               in_frequency_hz,
  input  logic [7:0]                in_duty_percent,
  output logic                      out_empty,
  input  logic                      out_pop,
  output logic [7:0]                out_reg_addr,
  output logic [7:0]                out_reg_value,
  output logic                      out_burst_continue,
  output logic                      out_wait_first,
  output logic                      out_error,
  output logic                      out_last
);

  logic [pwe_pkg::OSC_W-1:0] osc_r;
  pwe_pkg::desc_t front_desc, back_desc;
  logic q_push, q_full, q_pop, q_valid;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      osc_r <= pwe_pkg::OSC_RESET;
    end else if (cfg_valid && cfg_ready) begin
      osc_r <= cfg_data;
    end
  end

  pwe_front #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .osc_i           (osc_r),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_command      (in_command),
    .in_channel      (in_channel),
    .in_frequency_hz (in_frequency_hz),
    .in_duty_percent (in_duty_percent),
    .desc_o          (front_desc),
    .q_push_o        (q_push),
    .q_full_i        (q_full)
  );

  pwe_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (q_push),
    .wdata_i (front_desc),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rdata_o (back_desc),
    .valid_o (q_valid)
  );

  pwe_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .desc_i             (back_desc),
    .q_valid_i          (q_valid),
    .q_pop_o            (q_pop),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_reg_addr       (out_reg_addr),
    .out_reg_value      (out_reg_value),
    .out_burst_continue (out_burst_continue),
    .out_wait_first     (out_wait_first),
    .out_error          (out_error),
    .out_last           (out_last)
  );

endmodule

>>> bench/tb_top.sv
// testbench for the pwm expander write sequencer: scoreboard, drivers and run control
class pwm_write_scoreboard;
  pwe_pkg::result_t write_q[$];
  logic [pwe_pkg::OSC_W-1:0] osc_hz;
  int unsigned num_ch;
  int errors;
  int checked;

  function new(int unsigned n);
    osc_hz  = pwe_pkg::OSC_RESET;
    num_ch  = n;
    errors  = 0;
    checked = 0;
  endfunction

  task report(string msg);
    if (errors < 40) begin
      $display("mismatch: %s", msg);
    end
    errors++;
  endtask

  function int pending();
    return write_q.size();
  endfunction

  function void add_write(logic [7:0] addr, logic [7:0] value, logic cont, logic wait_ms,
                          logic err, logic fin);
    pwe_pkg::result_t r;
    r.reg_addr       = addr;
    r.reg_value      = value;
    r.burst_continue = cont;
    r.wait_first     = wait_ms;
    r.error          = err;
    r.last           = fin;
    write_q.push_back(r);
  endfunction

  // sleep, prescale, wake, then restart after the 1 ms wait
  function void add_freq_program(int unsigned freq, logic fin);
    int unsigned fc;
    int unsigned pre;
    fc = freq;
    if (fc < pwe_pkg::FREQ_MIN) fc = pwe_pkg::FREQ_MIN;
    if (fc > pwe_pkg::FREQ_MAX) fc = pwe_pkg::FREQ_MAX;
    pre = (int'(osc_hz) + 2048 * fc) / (4096 * fc);
    if (pre < pwe_pkg::PRE_MIN) pre = pwe_pkg::PRE_MIN;
    if (pre > pwe_pkg::PRE_MAX) pre = pwe_pkg::PRE_MAX;
    add_write(pwe_pkg::ADDR_MODE1, pwe_pkg::MODE1_SLEEP_AI, 1'b0, 1'b0, 1'b0, 1'b0);
    add_write(pwe_pkg::ADDR_PRESCALE, pre[7:0], 1'b0, 1'b0, 1'b0, 1'b0);
    add_write(pwe_pkg::ADDR_MODE1, pwe_pkg::MODE1_AUTO_INC, 1'b0, 1'b0, 1'b0, 1'b0);
    add_write(pwe_pkg::ADDR_MODE1, pwe_pkg::MODE1_RESTART_AI, 1'b0, 1'b1, 1'b0, fin);
  endfunction

  function void note_command(logic cmd, logic [7:0] ch, logic [15:0] freq, logic [7:0] duty);
    int unsigned d;
    int unsigned on_cnt;
    int unsigned off_cnt;
    logic [7:0] base;
    if (!cmd) begin
      add_write(pwe_pkg::ADDR_MODE2, pwe_pkg::MODE2_INIT, 1'b0, 1'b0, 1'b0, 1'b0);
      add_freq_program(pwe_pkg::FREQ_INIT, 1'b1);
      return;
    end
    // channel check comes first, zero frequency gives the same rejection
    if (ch >= num_ch || freq == 16'd0) begin
      add_write(8'h00, 8'h00, 1'b0, 1'b0, 1'b1, 1'b1);
      return;
    end
    d = (duty > pwe_pkg::DUTY_MAX) ? pwe_pkg::DUTY_MAX : duty;
    on_cnt  = 0;
    off_cnt = 0;
    if (d == 0) begin
      off_cnt = pwe_pkg::PWM_FULL;
    end else if (d == pwe_pkg::DUTY_MAX) begin
      on_cnt = pwe_pkg::PWM_FULL;
    end else begin
      off_cnt = (d * 4095) / 100;
    end
    add_freq_program(freq, 1'b0);
    base = pwe_pkg::REG_LED_BASE + 8'(4 * ch);
    add_write(base, on_cnt[7:0], 1'b0, 1'b0, 1'b0, 1'b0);
    add_write(base + 8'd1, on_cnt[15:8], 1'b1, 1'b0, 1'b0, 1'b0);
    add_write(base + 8'd2, off_cnt[7:0], 1'b1, 1'b0, 1'b0, 1'b0);
    add_write(base + 8'd3, off_cnt[15:8], 1'b1, 1'b0, 1'b0, 1'b1);
  endfunction

  task cmp_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want) begin
      report($sformatf("write %0d %s got %h want %h", checked, name, got, want));
    end
  endtask

  task check_write(pwe_pkg::result_t got);
    pwe_pkg::result_t want;
    if (write_q.size() == 0) begin
      report($sformatf("unexpected write addr %h value %h", got.reg_addr, got.reg_value));
      return;
    end
    want = write_q.pop_front();
    cmp_field("reg_addr", got.reg_addr, want.reg_addr);
    cmp_field("reg_value", got.reg_value, want.reg_value);
    cmp_field("burst_continue", got.burst_continue, want.burst_continue);
    cmp_field("wait_first", got.wait_first, want.wait_first);
    cmp_field("error", got.error, want.error);
    cmp_field("last", got.last, want.last);
    checked++;
  endtask
endclass

module tb_top;
  localparam int NUM_CH = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam int ITEMS_PER_PHASE = 80;
  localparam int NUM_PHASES = 6;

  logic                      clk;
  logic                      rst_n;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [pwe_pkg::OSC_W-1:0] cfg_data;
  logic                      in_push;
  logic                      in_full;
  logic                      in_command;
  logic [7:0]                in_channel;
  logic [15:0]               in_frequency_hz;
  logic [7:0]                in_duty_percent;
  logic                      out_empty;
  logic                      out_pop = 1'b0;
  logic [7:0]                out_reg_addr;
  logic [7:0]                out_reg_value;
  logic                      out_burst_continue;
  logic                      out_wait_first;
  logic                      out_error;
  logic                      out_last;
  pwe_pkg::result_t          out_write;

  int send_idle_pct;
  int pop_idle_pct;
  int cycle_cnt;
  pwm_write_scoreboard sb;

  pwm_expander_write_sequencer_top #(
    .NUM_CHANNELS(NUM_CH)
  ) u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_data           (cfg_data),
    .in_push            (in_push),
    .in_full            (in_full),
    .in_command         (in_command),
    .in_channel         (in_channel),
    .in_frequency_hz    (in_frequency_hz),
    .in_duty_percent    (in_duty_percent),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_reg_addr       (out_reg_addr),
    .out_reg_value      (out_reg_value),
    .out_burst_continue (out_burst_continue),
    .out_wait_first     (out_wait_first),
    .out_error          (out_error),
    .out_last           (out_last)
  );

  assign out_write = {out_reg_addr, out_reg_value, out_burst_continue, out_wait_first,
                      out_error, out_last};

  initial begin
    clk = 1'b0;
  end

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_pop <= ($urandom_range(99) >= pop_idle_pct);
  end

  // both handshakes sampled with pre-edge values, as the block sees them
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_push && !in_full) begin
        sb.note_command(in_command, in_channel, in_frequency_hz, in_duty_percent);
      end
      if (out_pop && !out_empty) begin
        sb.check_write(out_write);
      end
    end
  end

  task send_command(logic cmd, logic [7:0] ch, logic [15:0] freq, logic [7:0] duty);
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push         <= 1'b1;
    in_command      <= cmd;
    in_channel      <= ch;
    in_frequency_hz <= freq;
    in_duty_percent <= duty;
    do @(posedge clk); while (in_full);
  endtask

  // stop sending and let every expected write come out
  task hold_until_drained();
    in_push <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task write_osc(logic [pwe_pkg::OSC_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.osc_hz = value;
  endtask

  task send_random_command();
    int unsigned sel;
    int unsigned pick;
    logic        cmd;
    logic [7:0]  ch;
    logic [15:0] freq;
    logic [7:0]  duty;
    sel  = $urandom_range(99);
    pick = $urandom_range(5);
    cmd  = 1'b1;
    ch   = 8'($urandom_range(NUM_CH - 1));
    freq = 16'($urandom_range(1, 1600));
    duty = 8'($urandom_range(100));
    if (sel < 8) begin
      // init ignores the other fields, so fill them with junk
      cmd  = 1'b0;
      ch   = 8'($urandom);
      freq = 16'($urandom);
      duty = 8'($urandom);
    end else if (sel < 14) begin
      ch = 8'($urandom_range(NUM_CH, 255));
    end else if (sel < 18) begin
      freq = 16'd0;
    end else if (sel < 30) begin
      freq = 16'($urandom_range(65535));
    end else if (sel < 40) begin
      duty = 8'($urandom_range(255));
    end else if (sel < 48) begin
      case (pick)
        0: freq = 16'd1;
        1: freq = 16'd23;
        2: freq = 16'd24;
        3: freq = 16'd25;
        4: freq = 16'd1526;
        default: freq = 16'd1527;
      endcase
    end else if (sel < 56) begin
      case (pick)
        0: duty = 8'd0;
        1: duty = 8'd1;
        2: duty = 8'd99;
        3: duty = 8'd100;
        4: duty = 8'd101;
        default: duty = 8'd255;
      endcase
    end
    send_command(cmd, ch, freq, duty);
  endtask

  initial begin
    logic [pwe_pkg::OSC_W-1:0] phase_osc [NUM_PHASES];
    sb = new(NUM_CH);
    rst_n           = 1'b0;
    cfg_valid       = 1'b0;
    cfg_data        = '0;
    in_push         = 1'b0;
    in_command      = 1'b0;
    in_channel      = '0;
    in_frequency_hz = '0;
    in_duty_percent = '0;
    cycle_cnt       = 0;
    send_idle_pct   = 21;
    pop_idle_pct    = 65;
    phase_osc[0] = 26'd1000000;
    phase_osc[1] = 26'd50000000;
    phase_osc[2] = 26'h3FFFFFF;
    phase_osc[3] = 26'd0;
    phase_osc[4] = 26'($urandom_range(1000000, 50000000));
    phase_osc[5] = pwe_pkg::OSC_RESET;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed commands at the reset oscillator value
    send_command(1'b0, 8'h00, 16'h0000, 8'h00);
    send_command(1'b0, 8'hFF, 16'hFFFF, 8'hFF);
    send_command(1'b0, 8'd16, 16'd0, 8'd0);
    send_command(1'b1, 8'd0, 16'd200, 8'd50);
    send_command(1'b1, 8'd15, 16'd1526, 8'd100);
    send_command(1'b1, 8'd15, 16'd1527, 8'd101);
    send_command(1'b1, 8'd0, 16'hFFFF, 8'hFF);
    send_command(1'b1, 8'd3, 16'd24, 8'd0);
    send_command(1'b1, 8'd4, 16'd23, 8'd1);
    send_command(1'b1, 8'd5, 16'd1, 8'd99);
    send_command(1'b1, 8'd6, 16'd25, 8'd100);
    send_command(1'b1, 8'd16, 16'd200, 8'd50);
    send_command(1'b1, 8'd255, 16'd200, 8'd50);
    send_command(1'b1, 8'd16, 16'd0, 8'd50);
    send_command(1'b1, 8'd7, 16'd0, 8'd50);
    send_command(1'b1, 8'd8, 16'h8000, 8'h80);
    send_command(1'b1, 8'd9, 16'h5555, 8'hAA);
    send_command(1'b1, 8'd10, 16'hAAAA, 8'h55);
    send_command(1'b1, 8'd1, 16'd1000, 8'd33);
    send_command(1'b1, 8'd2, 16'd60, 8'd67);
    hold_until_drained();

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p == 2) begin
        send_idle_pct = 65;
        pop_idle_pct  = 21;
      end else if (p == 4) begin
        send_idle_pct = 0;
        pop_idle_pct  = 0;
      end
      write_osc(phase_osc[p]);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (i == ITEMS_PER_PHASE / 2) begin
          hold_until_drained();
        end
        send_random_command();
      end
      hold_until_drained();
    end

    // catch any write the block emits beyond what was predicted
    repeat (40) @(posedge clk);
    if (sb.pending() != 0) begin
      sb.report($sformatf("%0d writes never arrived", sb.pending()));
    end
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

>>> sim.f
rtl/pwe_pkg.sv
rtl/pwe_front.sv
rtl/pwe_queue.sv
rtl/pwe_back.sv
rtl/pwm_expander_write_sequencer_top.sv
bench/tb_top.sv
